// ===== src/slrg_pkg.sv =====
// Shared constants of the subtractive lagged random generator.
package slrg_pkg;

  // Index and address width of the lag table
  localparam int unsigned IdxW = 6;

  // Lag table geometry and lags
  localparam logic [IdxW-1:0] TableLen   = 6'd55;
  localparam logic [IdxW-1:0] LastIdx    = 6'd54;
  localparam logic [IdxW-1:0] ShortLag   = 6'd24;
  localparam logic [IdxW-1:0] LongOffset = 6'd31;

  // Warmup stride and modulus over table positions
  localparam logic [IdxW-1:0] WarmStride = 6'd21;
  localparam logic [IdxW-1:0] WarmMod    = 6'd54;

  // Command codes of an input word
  localparam logic CmdReseed = 1'b0;
  localparam logic CmdDraw   = 1'b1;

endpackage

// ===== src/subtractive_lagged_random_generator.sv =====
// Top level of the subtractive lagged random generator (lags 55 and 24).
//
// Input channel: in_valid_i / in_stall_o carry one word of cmd_i and seed_i.
// cmd_i = reseed clears the table, writes the seed and runs a 54-step warmup,
// then three refresh passes; it returns no word. cmd_i = draw returns one
// word on random_value_o over out_valid_o / out_stall_i.
// A plain draw reads its word on acceptance and loads the result register in
// the data state; the block takes no new word until it is back in idle.
// Every 54th draw first runs one refresh pass, word by word, since the table
// sits in one RAM with one write port and each word is read, subtracted and
// written back once per cycle.
// The result register lets the block take the next word while a result
// waits; a draw whose result finds the register still held waits there and
// stalls the input until the receiver takes the old word.
// After reset the table reads as all zero (per-entry valid bits) and the
// read index is zero, so draws return zero until the first reseed.
// Values are unsigned fractions of one with FRACTION_BITS bits inside and
// 32 bits at the ports.
module subtractive_lagged_random_generator #(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_value_o
);

  localparam int unsigned IdxW = slrg_pkg::IdxW;
  localparam int unsigned Depth = 55;

  // Warmup start value 1e-9 as a fraction of one
  localparam logic [64:0] WarmFull = (65'd1 << FRACTION_BITS) / 65'd1000000000;
  localparam logic [FRACTION_BITS-1:0] WarmStart = WarmFull[FRACTION_BITS-1:0];

  // Sequencer states
  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StWarm     = 3'd1;
  localparam logic [2:0] StRefresh  = 3'd2;
  localparam logic [2:0] StDrawData = 3'd3;

  logic [2:0]               state_q, state_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [IdxW-1:0]          k_q, k_d;
  logic [1:0]               pass_q, pass_d;
  logic                     draw_q, draw_d;
  logic [IdxW-1:0]          pos_q, pos_d;
  logic [FRACTION_BITS-1:0] cur_q, cur_d;
  logic [FRACTION_BITS-1:0] prev_q, prev_d;
  logic                     wr_pend_q, wr_pend_d;
  logic [IdxW-1:0]          wr_addr_q, wr_addr_d;
  logic [Depth-1:0]         valid_q, valid_d;
  logic                     va_q, vb_q;
  logic                     out_valid_q, out_valid_d;
  logic [31:0]              out_q, out_d;

  logic                     in_acc;
  logic [IdxW-1:0]          next_idx;
  logic [IdxW:0]            pos_sum;
  logic                     ram_we;
  logic [IdxW-1:0]          ram_waddr;
  logic [FRACTION_BITS-1:0] ram_wdata;
  logic [IdxW-1:0]          addr_a, addr_b;
  logic [FRACTION_BITS-1:0] rd_a, rd_b;
  logic [FRACTION_BITS-1:0] word_a, word_b;
  logic [FRACTION_BITS-1:0] seed_word;
  logic [31:0]              out_word;
  logic                     out_free;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign next_idx   = IdxW'(idx_q + 1'b1);
  assign pos_sum    = {1'b0, pos_q} + {1'b0, slrg_pkg::WarmStride};
  assign out_free   = !out_valid_q || !out_stall_i;

  // Mask entries never written since the last clear
  assign word_a = va_q ? rd_a : '0;
  assign word_b = vb_q ? rd_b : '0;

  // Convert between the 32-bit port format and the internal fraction
  if (FRACTION_BITS >= 32) begin : g_wide
    assign seed_word = FRACTION_BITS'(seed_i) << (FRACTION_BITS - 32);
    assign out_word  = 32'(word_a >> (FRACTION_BITS - 32));
  end else begin : g_narrow
    assign seed_word = FRACTION_BITS'(seed_i >> (32 - FRACTION_BITS));
    assign out_word  = 32'(word_a) << (32 - FRACTION_BITS);
  end

  // Pick the refresh partner: long lag for the low words, short lag above
  assign addr_b = (k_q < slrg_pkg::ShortLag) ? IdxW'(k_q + slrg_pkg::LongOffset)
                                             : IdxW'(k_q - slrg_pkg::ShortLag);

  // Pick the first read address
  always_comb begin
    case (state_q)
      StIdle:    addr_a = next_idx;
      StRefresh: addr_a = (k_q < slrg_pkg::TableLen) ? k_q : idx_q;
      default:   addr_a = idx_q;
    endcase
  end

  // Drive the single write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = word_a - word_b;
    case (state_q)
      StIdle: begin
        ram_we    = in_acc && (cmd_i == slrg_pkg::CmdReseed);
        ram_waddr = slrg_pkg::LastIdx;
        ram_wdata = seed_word;
      end
      StWarm: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = cur_q;
      end
      StRefresh: begin
        ram_we = wr_pend_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  slrg_ram #(
    .WIDTH(FRACTION_BITS),
    .DEPTH(Depth)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(addr_a),
    .raddr_b_i(addr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  // Sequence reseed, warmup, refresh passes and draws
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    k_d         = k_q;
    pass_d      = pass_q;
    draw_d      = draw_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    // Clear the table on reseed, then mark every written entry
    if (state_q == StIdle && in_acc && cmd_i == slrg_pkg::CmdReseed) begin
      valid_d = '0;
    end
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (cmd_i == slrg_pkg::CmdReseed) begin
            cur_d   = WarmStart;
            prev_d  = seed_word;
            pos_d   = slrg_pkg::WarmStride;
            k_d     = IdxW'(1);
            state_d = StWarm;
          end else if (next_idx >= slrg_pkg::TableLen) begin
            idx_d     = IdxW'(1);
            k_d       = '0;
            pass_d    = 2'd0;
            draw_d    = 1'b1;
            wr_pend_d = 1'b0;
            state_d   = StRefresh;
          end else begin
            idx_d   = next_idx;
            state_d = StDrawData;
          end
        end
      end
      StWarm: begin
        cur_d  = prev_q - cur_q;
        prev_d = cur_q;
        pos_d  = (pos_sum >= {1'b0, slrg_pkg::WarmMod})
                 ? IdxW'(pos_sum - {1'b0, slrg_pkg::WarmMod}) : IdxW'(pos_sum);
        k_d    = IdxW'(k_q + 1'b1);
        if (k_q == slrg_pkg::WarmMod) begin
          k_d       = '0;
          pass_d    = 2'd2;
          draw_d    = 1'b0;
          wr_pend_d = 1'b0;
          state_d   = StRefresh;
        end
      end
      StRefresh: begin
        if (k_q < slrg_pkg::TableLen) begin
          wr_pend_d = 1'b1;
          wr_addr_d = k_q;
          k_d       = IdxW'(k_q + 1'b1);
        end else begin
          wr_pend_d = 1'b0;
          k_d       = '0;
          if (pass_q == 2'd0) begin
            if (draw_q) begin
              state_d = StDrawData;
            end else begin
              idx_d   = '0;
              state_d = StIdle;
            end
          end else begin
            pass_d = pass_q - 2'd1;
          end
        end
      end
      StDrawData: begin
        // Hold and re-read while the result register is still taken
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = out_word;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      k_q         <= '0;
      pass_q      <= '0;
      draw_q      <= 1'b0;
      wr_pend_q   <= 1'b0;
      valid_q     <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      pass_q      <= pass_d;
      draw_q      <= draw_d;
      wr_pend_q   <= wr_pend_d;
      valid_q     <= valid_d;
      va_q        <= (addr_a < slrg_pkg::TableLen) ? valid_q[addr_a] : 1'b0;
      vb_q        <= (addr_b < slrg_pkg::TableLen) ? valid_q[addr_b] : 1'b0;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    wr_addr_q <= wr_addr_d;
    out_q     <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_q;

  // The read index stays inside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < slrg_pkg::TableLen)
    else $error("read index out of table range");

  // Write-back only happens inside a refresh pass
  a_wb_in_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> state_q == StRefresh)
    else $error("pending write-back outside refresh");

  // The partner read never hits the word being written back
  a_no_partner_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> wr_addr_q != addr_b)
    else $error("partner read collides with write-back");

  // A draw without refresh reaches the data state next cycle
  a_draw_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_i == slrg_pkg::CmdDraw && next_idx < slrg_pkg::TableLen)
      |=> state_q == StDrawData)
    else $error("draw did not go to the data state");

endmodule

// ===== src/slrg_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module slrg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 55
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two entries into output registers
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
